// ===== hdl/fpfa_pkg.sv =====
// Package: shared types, codes and defaults for the fixed partition fit allocator.
`timescale 1ns / 1ps
package fpfa_pkg;

  localparam int NUM_SLOTS_DEF   = 16;
  localparam int OWNER_LIMIT_DEF = 255;

  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 4;
  localparam int SIZE_W   = 16;
  localparam int OWNER_W  = 8;
  localparam int MODE_W   = 2;
  localparam int ACTIVE_W = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int LIMIT_W  = 16;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef enum logic [MODE_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIT_MODE = 1'd0,
    REG_ACTIVE   = 1'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SETUP  = 2'd1,
    ST_SCAN   = 2'd2,
    ST_COMMIT = 2'd3
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;
    logic scan_step;
    logic commit;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic cmd_alloc;
    logic alloc_go;
    logic scan_last;
  } stat_t;

endpackage

// ===== hdl/fpfa_ctrl.sv =====
// Controller: sequences setup, the slot scan of an allocate, and commit for each command beat.
`timescale 1ns / 1ps
module fpfa_ctrl
  import fpfa_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output ctl_t  ctl,
  output logic  busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.latch = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (stat.cmd_alloc && stat.alloc_go) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_SCAN: begin
        ctl.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        ctl.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/fpfa_datapath.sv =====
// Datapath: partition table, config registers, fit comparator and result registers.
`timescale 1ns / 1ps
module fpfa_datapath
  import fpfa_pkg::*;
#(
  parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
  parameter int OWNER_LIMIT = OWNER_LIMIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [SLOT_W-1:0]     in_slot,
  input  logic [SIZE_W-1:0]     in_req_size,
  input  logic [OWNER_W-1:0]    in_owner_id,
  input  ctl_t                  ctl,
  output stat_t                 stat,
  output logic                  out_strobe,
  output logic                  out_ok,
  output logic [SLOT_W-1:0]     out_slot,
  output logic [SIZE_W-1:0]     out_size,
  output logic                  out_busy,
  output logic [OWNER_W-1:0]    out_owner
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int N_W   = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;
  localparam logic [LIMIT_W-1:0] LIMIT = LIMIT_W'(OWNER_LIMIT);
  localparam logic [N_W-1:0]     NSLOT = N_W'(NUM_SLOTS);

  logic [MODE_W-1:0]   fit_mode_r;
  logic [ACTIVE_W-1:0] active_r;

  logic [SIZE_W-1:0]  size_r  [NUM_SLOTS];
  logic               sbusy_r [NUM_SLOTS];
  logic [OWNER_W-1:0] owner_r [NUM_SLOTS];

  logic [CMD_W-1:0]   cmd_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [SIZE_W-1:0]  req_r;
  logic [OWNER_W-1:0] own_r;

  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   pick_r;
  logic [SIZE_W-1:0]  pick_size_r;
  logic               found_r;

  logic               strobe_r;
  logic               ok_r;
  logic [SLOT_W-1:0]  oslot_r;
  logic [SIZE_W-1:0]  osize_r;
  logic               obusy_r;
  logic [OWNER_W-1:0] oowner_r;

  logic [N_W-1:0]     active_ext;
  logic [N_W-1:0]     n_use;
  logic               in_range;
  logic [IDX_W-1:0]   sel_idx;
  logic [IDX_W-1:0]   rd_idx;
  logic [SIZE_W-1:0]  rd_size;
  logic               rd_busy;
  logic [OWNER_W-1:0] rd_owner;
  logic               fits;
  logic               take;
  logic               alloc_hit;
  logic               lq_hit;

  always_comb begin
    active_ext = N_W'(active_r);
    n_use      = (active_ext > NSLOT) ? NSLOT : active_ext;
    in_range   = N_W'(slot_r) < n_use;
    sel_idx    = IDX_W'(slot_r);
    rd_idx     = ctl.scan_step ? idx_r : sel_idx;
    rd_size    = size_r[rd_idx];
    rd_busy    = sbusy_r[rd_idx];
    rd_owner   = owner_r[rd_idx];
    fits       = !rd_busy && (rd_size >= req_r);
    case (fit_mode_r)
      FIT_BEST:  take = fits && (!found_r || (rd_size < pick_size_r));
      FIT_WORST: take = fits && (!found_r || (rd_size > pick_size_r));
      default:   take = fits && !found_r;
    endcase
    alloc_hit = (cmd_r == CMD_ALLOC) && found_r;
    lq_hit    = ((cmd_r == CMD_LOAD) || (cmd_r == CMD_QUERY)) && in_range;

    stat.cmd_alloc = (cmd_r == CMD_ALLOC);
    stat.alloc_go  = ({{(LIMIT_W-OWNER_W){1'b0}}, own_r} <= LIMIT) && (n_use != '0);
    stat.scan_last = (N_W'(idx_r) + N_W'(1)) == n_use;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r <= FIT_FIRST;
      active_r   <= ACTIVE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIT_MODE: fit_mode_r <= cfg_wdata[MODE_W-1:0];
        REG_ACTIVE:   active_r   <= cfg_wdata[ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // command latch and scan registers
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r  <= in_cmd;
      slot_r <= in_slot;
      req_r  <= in_req_size;
      own_r  <= in_owner_id;
      idx_r  <= '0;
    end else if (ctl.scan_step) begin
      idx_r <= idx_r + IDX_W'(1);
      if (take) begin
        pick_r      <= idx_r;
        pick_size_r <= rd_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.latch) begin
      found_r <= 1'b0;
    end else if (ctl.scan_step && take) begin
      found_r <= 1'b1;
    end
  end

  // partition table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        size_r[i]  <= '0;
        sbusy_r[i] <= 1'b0;
      end
    end else if (ctl.commit) begin
      if (alloc_hit) begin
        sbusy_r[pick_r] <= 1'b1;
        owner_r[pick_r] <= own_r;
      end else if (lq_hit && (cmd_r == CMD_LOAD)) begin
        size_r[sel_idx]  <= req_r;
        sbusy_r[sel_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctl.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      if (alloc_hit) begin
        ok_r     <= 1'b1;
        oslot_r  <= SLOT_W'(pick_r);
        osize_r  <= pick_size_r;
        obusy_r  <= 1'b1;
        oowner_r <= own_r;
      end else if (lq_hit) begin
        ok_r    <= 1'b1;
        oslot_r <= slot_r;
        if (cmd_r == CMD_LOAD) begin
          osize_r  <= req_r;
          obusy_r  <= 1'b0;
          oowner_r <= '0;
        end else begin
          osize_r  <= rd_size;
          obusy_r  <= rd_busy;
          oowner_r <= rd_busy ? rd_owner : '0;
        end
      end else if ((cmd_r == CMD_LOAD) || (cmd_r == CMD_QUERY)) begin
        ok_r     <= 1'b0;
        oslot_r  <= slot_r;
        osize_r  <= '0;
        obusy_r  <= 1'b0;
        oowner_r <= '0;
      end else begin
        ok_r     <= 1'b0;
        oslot_r  <= '0;
        osize_r  <= '0;
        obusy_r  <= 1'b0;
        oowner_r <= '0;
      end
    end
  end

  assign out_strobe = strobe_r;
  assign out_ok     = ok_r;
  assign out_slot   = oslot_r;
  assign out_size   = osize_r;
  assign out_busy   = obusy_r;
  assign out_owner  = oowner_r;

endmodule

// ===== hdl/fixed_partition_fit_allocator_core.sv =====
// Top level: fixed partition allocator with first, best and worst fit placement.
// Load and query: the start beat is latched, setup and commit follow, then the strobe is
// registered; a new start is taken when busy is low. Allocate: a scan state between setup
// and commit covers n = min(active_slots, NUM_SLOTS) slots with one size comparator, one
// slot per cycle; it is skipped when the owner is over the limit or n = 0. Results are
// strobed for one cycle; the receiver cannot stall.
// Synchronous reset: all slots size 0 and free, first fit, 16 active slots.
`timescale 1ns / 1ps
module fixed_partition_fit_allocator_core
  import fpfa_pkg::*;
#(
  parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
  parameter int OWNER_LIMIT = OWNER_LIMIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [SLOT_W-1:0]     in_slot,
  input  logic [SIZE_W-1:0]     in_req_size,
  input  logic [OWNER_W-1:0]    in_owner_id,
  output logic                  out_strobe,
  output logic                  out_ok,
  output logic [SLOT_W-1:0]     out_slot,
  output logic [SIZE_W-1:0]     out_size,
  output logic                  out_busy,
  output logic [OWNER_W-1:0]    out_owner
);

  ctl_t  ctl;
  stat_t stat;

  fpfa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  fpfa_datapath #(
    .NUM_SLOTS   (NUM_SLOTS),
    .OWNER_LIMIT (OWNER_LIMIT)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_cmd      (in_cmd),
    .in_slot     (in_slot),
    .in_req_size (in_req_size),
    .in_owner_id (in_owner_id),
    .ctl         (ctl),
    .stat        (stat),
    .out_strobe  (out_strobe),
    .out_ok      (out_ok),
    .out_slot    (out_slot),
    .out_size    (out_size),
    .out_busy    (out_busy),
    .out_owner   (out_owner)
  );

endmodule

// ===== dv/fixed_partition_fit_allocator_core_tb.sv =====
// Testbench: directed and random checking of the fixed partition fit allocator core.
`timescale 1ns / 1ps
module fixed_partition_fit_allocator_core_tb;
  import fpfa_pkg::*;

  localparam logic [CMD_W-1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [MODE_W-1:0] FIT_UNUSED  = 2'd3;
  localparam int                STALL_LIMIT = 2000;
  localparam int                SETTLE      = 25;
  localparam int                PHASES      = 10;

  typedef struct packed {
    logic               ok;
    logic [SLOT_W-1:0]  idx;
    logic [SIZE_W-1:0]  len;
    logic               taken;
    logic [OWNER_W-1:0] owner;
  } slot_report_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  start;
  logic                  busy;
  logic [CMD_W-1:0]      in_cmd;
  logic [SLOT_W-1:0]     in_slot;
  logic [SIZE_W-1:0]     in_req_size;
  logic [OWNER_W-1:0]    in_owner_id;
  logic                  out_strobe;
  logic                  out_ok;
  logic [SLOT_W-1:0]     out_slot;
  logic [SIZE_W-1:0]     out_size;
  logic                  out_busy;
  logic [OWNER_W-1:0]    out_owner;

  // partition table mirror and register copies
  logic [SIZE_W-1:0]   part_len   [NUM_SLOTS_DEF];
  logic                part_taken [NUM_SLOTS_DEF];
  logic [OWNER_W-1:0]  part_owner [NUM_SLOTS_DEF];
  logic [MODE_W-1:0]   fit_sel;
  logic [ACTIVE_W-1:0] slots_on;

  slot_report_t pending_reports[$];
  int errors;
  int idle_cycles;
  int n_cmds[4];
  int n_placed;
  int n_cfg;
  bit calm;

  fixed_partition_fit_allocator_core #(
    .NUM_SLOTS  (NUM_SLOTS_DEF),
    .OWNER_LIMIT(OWNER_LIMIT_DEF)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .start      (start),
    .busy       (busy),
    .in_cmd     (in_cmd),
    .in_slot    (in_slot),
    .in_req_size(in_req_size),
    .in_owner_id(in_owner_id),
    .out_strobe (out_strobe),
    .out_ok     (out_ok),
    .out_slot   (out_slot),
    .out_size   (out_size),
    .out_busy   (out_busy),
    .out_owner  (out_owner)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int find_fit(logic [SIZE_W-1:0] need, int n);
    int pick;
    bit done;
    pick = -1;
    done = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!done && !part_taken[i] && part_len[i] >= need) begin
        if (pick < 0) begin
          pick = i;
          done = (fit_sel != FIT_BEST) && (fit_sel != FIT_WORST);
        end else if (fit_sel == FIT_BEST && part_len[i] < part_len[pick]) begin
          pick = i;
        end else if (fit_sel == FIT_WORST && part_len[i] > part_len[pick]) begin
          pick = i;
        end
      end
    end
    return pick;
  endfunction

  function automatic slot_report_t apply_command(logic [CMD_W-1:0] cmd,
                                                 logic [SLOT_W-1:0] s,
                                                 logic [SIZE_W-1:0] len,
                                                 logic [OWNER_W-1:0] own);
    slot_report_t r;
    int n;
    int pick;
    r = '0;
    n = (int'(slots_on) > NUM_SLOTS_DEF) ? NUM_SLOTS_DEF : int'(slots_on);
    pick = -1;
    case (cmd)
      CMD_LOAD, CMD_QUERY: begin
        r.idx = s;
        if (int'(s) < n) begin
          if (cmd == CMD_LOAD) begin
            part_len[s]   = len;
            part_taken[s] = 1'b0;
            part_owner[s] = '0;
          end
          r.ok    = 1'b1;
          r.len   = part_len[s];
          r.taken = part_taken[s];
          r.owner = part_taken[s] ? part_owner[s] : '0;
        end
      end
      CMD_ALLOC: begin
        if (int'(own) <= OWNER_LIMIT_DEF) pick = find_fit(len, n);
        if (pick >= 0) begin
          part_taken[pick] = 1'b1;
          part_owner[pick] = own;
          r.ok    = 1'b1;
          r.idx   = SLOT_W'(pick);
          r.len   = part_len[pick];
          r.taken = 1'b1;
          r.owner = own;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    errors++;
    if (errors <= 30)
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    slot_report_t got;
    slot_report_t want;
    if (rst_n && out_strobe) begin
      got = {out_ok, out_slot, out_size, out_busy, out_owner};
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected beat (slot)", 0, got.idx);
      end else begin
        want = pending_reports.pop_front();
        if (got.ok !== want.ok) report_mismatch("ok", want.ok, got.ok);
        if (got.idx !== want.idx) report_mismatch("slot", want.idx, got.idx);
        if (got.len !== want.len) report_mismatch("size", want.len, got.len);
        if (got.taken !== want.taken) report_mismatch("busy", want.taken, got.taken);
        if (got.owner !== want.owner) report_mismatch("owner", want.owner, got.owner);
      end
    end
    if (rst_n && start && !busy) begin
      want = apply_command(in_cmd, in_slot, in_req_size, in_owner_id);
      pending_reports.push_back(want);
      n_cmds[in_cmd]++;
      if (in_cmd == CMD_ALLOC && want.ok) n_placed++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || out_strobe || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_reports.size());
      $display("** fixed_partition_fit_allocator_core: FAILED **");
      $finish;
    end
  end

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] s,
                          input logic [SIZE_W-1:0] len, input logic [OWNER_W-1:0] own);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_cmd      <= cmd;
    in_slot     <= s;
    in_req_size <= len;
    in_owner_id <= own;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0 || busy);
  endtask

  task automatic set_config(input logic [MODE_W-1:0] mode,
                            input logic [ACTIVE_W-1:0] active);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_FIT_MODE;
    cfg_wdata <= CFG_DATA_W'(mode);
    @(posedge clk);
    fit_sel = mode;
    cfg_index <= REG_ACTIVE;
    cfg_wdata <= CFG_DATA_W'(active);
    @(posedge clk);
    slots_on = active;
    cfg_we <= 1'b0;
    n_cfg++;
  endtask

  task automatic test_load_query();
    send_cmd(CMD_QUERY, 4'd5, 16'h0000, 8'h00);
    send_cmd(CMD_LOAD, 4'd0, 16'hFFFF, 8'hFF);
    send_cmd(CMD_LOAD, 4'd15, 16'h0000, 8'h00);
    send_cmd(CMD_QUERY, 4'd15, 16'h1234, 8'hAA);
    send_cmd(CMD_QUERY, 4'd0, 16'h0000, 8'h00);
    send_cmd(CMD_UNUSED, 4'd15, 16'hFFFF, 8'hFF);
  endtask

  task automatic test_fit_rules();
    set_config(FIT_BEST, 5'd4);
    send_cmd(CMD_LOAD, 4'd0, 16'd300, 8'h00);
    send_cmd(CMD_LOAD, 4'd1, 16'd100, 8'h00);
    send_cmd(CMD_LOAD, 4'd2, 16'd50, 8'h00);
    send_cmd(CMD_LOAD, 4'd3, 16'd200, 8'h00);
    send_cmd(CMD_ALLOC, 4'd0, 16'd60, 8'hFF);
    set_config(FIT_WORST, 5'd4);
    send_cmd(CMD_ALLOC, 4'd0, 16'd60, 8'h00);
    set_config(FIT_FIRST, 5'd4);
    send_cmd(CMD_ALLOC, 4'd0, 16'd60, 8'h3C);
    set_config(FIT_UNUSED, 5'd4);
    send_cmd(CMD_ALLOC, 4'd0, 16'd10, 8'hC3);
    send_cmd(CMD_ALLOC, 4'd0, 16'd1, 8'h01);
    send_cmd(CMD_QUERY, 4'd1, 16'h0000, 8'h00);
  endtask

  task automatic test_active_range();
    set_config(FIT_FIRST, 5'd0);
    send_cmd(CMD_LOAD, 4'd0, 16'd9, 8'h00);
    send_cmd(CMD_QUERY, 4'd0, 16'd0, 8'h00);
    send_cmd(CMD_ALLOC, 4'd0, 16'd0, 8'h11);
    set_config(FIT_BEST, 5'd1);
    send_cmd(CMD_QUERY, 4'd1, 16'd0, 8'h00);
    send_cmd(CMD_LOAD, 4'd0, 16'd7, 8'h00);
    send_cmd(CMD_ALLOC, 4'd0, 16'd0, 8'h5A);
    send_cmd(CMD_ALLOC, 4'd0, 16'hFFFF, 8'hA5);
    set_config(FIT_WORST, 5'd31);
    send_cmd(CMD_QUERY, 4'd15, 16'd0, 8'h00);
    send_cmd(CMD_LOAD, 4'd15, 16'hFFFF, 8'h00);
    send_cmd(CMD_ALLOC, 4'd0, 16'hFFFF, 8'h80);
  endtask

  task automatic test_random();
    int n_eff;
    int x;
    int phase_items;
    logic [MODE_W-1:0]   mode;
    logic [ACTIVE_W-1:0] act;
    logic [CMD_W-1:0]    c;
    logic [SLOT_W-1:0]   s;
    logic [SIZE_W-1:0]   len;
    logic [OWNER_W-1:0]  own;
    for (int p = 0; p < PHASES; p++) begin
      mode = (p < 4) ? MODE_W'(p) : MODE_W'($urandom_range(0, 3));
      case (p)
        0: act = 5'd16;
        1: act = 5'd1;
        2: act = 5'd31;
        3: act = 5'd0;
        4: act = 5'd17;
        default: act = ($urandom_range(0, 4) == 0) ? ACTIVE_W'($urandom_range(17, 31))
                                                  : ACTIVE_W'($urandom_range(2, 16));
      endcase
      phase_items = (act == 0) ? 30 : 113;
      set_config(mode, act);
      n_eff = (int'(act) > NUM_SLOTS_DEF) ? NUM_SLOTS_DEF : int'(act);
      for (int k = 0; k < phase_items; k++) begin
        if (k % 32 == 0) calm = ($urandom_range(0, 3) == 0);
        x = $urandom_range(0, 99);
        if (x < 35) c = CMD_LOAD;
        else if (x < 75) c = CMD_ALLOC;
        else if (x < 95) c = CMD_QUERY;
        else c = CMD_UNUSED;
        if (n_eff > 0 && $urandom_range(0, 9) < 8) s = SLOT_W'($urandom_range(0, n_eff - 1));
        else s = SLOT_W'($urandom_range(0, 15));
        case ($urandom_range(0, 3))
          0: len = SIZE_W'($urandom_range(0, 65535));
          1: len = SIZE_W'($urandom_range(1, 8) * 16);
          2: len = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          default: len = SIZE_W'($urandom_range(0, 255));
        endcase
        own = OWNER_W'($urandom_range(0, 255));
        send_cmd(c, s, len, own);
      end
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_FIT_MODE;
    cfg_wdata   <= '0;
    start       <= 1'b0;
    in_cmd      <= CMD_LOAD;
    in_slot     <= '0;
    in_req_size <= '0;
    in_owner_id <= '0;
    errors   = 0;
    n_placed = 0;
    n_cfg    = 0;
    calm     = 1'b0;
    foreach (n_cmds[i]) n_cmds[i] = 0;
    for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
      part_len[i]   = '0;
      part_taken[i] = 1'b0;
      part_owner[i] = '0;
    end
    fit_sel  = FIT_FIRST;
    slots_on = ACTIVE_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_load_query();
    test_fit_rules();
    test_active_range();
    test_random();

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d loads, %0d allocates (%0d placed), %0d queries, %0d unused codes",
             n_cmds[CMD_LOAD], n_cmds[CMD_ALLOC], n_placed, n_cmds[CMD_QUERY],
             n_cmds[CMD_UNUSED]);
    $display("over %0d register settings; %0d mismatches", n_cfg, errors);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("** fixed_partition_fit_allocator_core: PASSED **");
    end else begin
      $display("** fixed_partition_fit_allocator_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/fpfa_pkg.sv
hdl/fpfa_ctrl.sv
hdl/fpfa_datapath.sv
hdl/fixed_partition_fit_allocator_core.sv
dv/fixed_partition_fit_allocator_core_tb.sv
